[hw/rtl/b64sc_pkg.sv]
// shared types, constants and alphabet mapping functions for the base64 codec
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;
    localparam logic [6:0] VAL_PAD        = 7'd64;
    localparam logic [6:0] VAL_BAD        = 7'd65;
    localparam logic [0:0] REG_DECODE_MODE = 1'b0;

    // results of one item, handed from front to back
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            data_ok;
        logic            bad;
        logic            msg_end;
    } b64sc_bundle_t;

    function automatic logic [7:0] sym_of(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
        begin
            r = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            r = 8'h2B;
        end
        else
        begin
            r = 8'h2F;
        end
        return r;
    endfunction

    // 0..63 for alphabet, VAL_PAD for '=', VAL_BAD otherwise
    function automatic logic [6:0] val_of(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c[6:0] - 7'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c[6:0] - 7'h61 + 7'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = c[6:0] - 7'h30 + 7'd52;
        end
        else if (c == 8'h2B)
        begin
            r = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            r = 7'd63;
        end
        else if (c == PAD_CHAR)
        begin
            r = VAL_PAD;
        end
        else
        begin
            r = VAL_BAD;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b64sc_front.sv]
// front end: bit regrouping state, mode register and per-item result bundle
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  logic          last_item,
    input  logic          take,
    input  logic          cfg_we,
    input  logic          cfg_mode,
    output logic          mode,
    output logic          has_result,
    output b64sc_bundle_t bundle
);

    logic       mode_reg;
    logic [5:0] buf_reg, buf_next;
    logic [2:0] held_reg, held_next;
    logic       pad_reg, pad_next;
    logic [6:0] code;
    logic [5:0] v6;
    logic [5:0] c0, c1, flush6;

    assign mode = mode_reg;
    assign code = val_of(data_byte);
    assign v6   = code[5:0];

    always_comb
    begin
        buf_next   = buf_reg;
        held_next  = held_reg;
        pad_next   = pad_reg;
        has_result = 1'b0;
        bundle     = '0;
        c0         = '0;
        c1         = '0;
        flush6     = '0;
        if (!mode_reg)
        begin
            has_result     = 1'b1;
            bundle.data_ok = 1'b1;
            bundle.msg_end = last_item;
            unique case (held_reg)
                3'd0:
                begin
                    c0     = data_byte[7:2];
                    flush6 = {data_byte[1:0], 4'b0000};
                    bundle.bytes[0] = sym_of(c0);
                    if (last_item)
                    begin
                        bundle.bytes[1] = sym_of(flush6);
                        bundle.bytes[2] = PAD_CHAR;
                        bundle.bytes[3] = PAD_CHAR;
                        bundle.last_idx = 2'd3;
                    end
                    buf_next  = {4'b0000, data_byte[1:0]};
                    held_next = 3'd2;
                end
                3'd2:
                begin
                    c0     = {buf_reg[1:0], data_byte[7:4]};
                    flush6 = {data_byte[3:0], 2'b00};
                    bundle.bytes[0] = sym_of(c0);
                    if (last_item)
                    begin
                        bundle.bytes[1] = sym_of(flush6);
                        bundle.bytes[2] = PAD_CHAR;
                        bundle.last_idx = 2'd2;
                    end
                    buf_next  = {2'b00, data_byte[3:0]};
                    held_next = 3'd4;
                end
                default:
                begin
                    c0 = {buf_reg[3:0], data_byte[7:6]};
                    c1 = data_byte[5:0];
                    bundle.bytes[0] = sym_of(c0);
                    bundle.bytes[1] = sym_of(c1);
                    bundle.last_idx = 2'd1;
                    buf_next  = '0;
                    held_next = 3'd0;
                end
            endcase
        end
        else
        begin
            if (code == VAL_PAD)
            begin
                pad_next = 1'b1;
            end
            else if (code == VAL_BAD || pad_reg)
            begin
                has_result = 1'b1;
                bundle.bad = 1'b1;
            end
            else
            begin
                unique case (held_reg)
                    3'd0:
                    begin
                        buf_next  = v6;
                        held_next = 3'd6;
                    end
                    3'd6:
                    begin
                        has_result      = 1'b1;
                        bundle.data_ok  = 1'b1;
                        bundle.bytes[0] = {buf_reg, v6[5:4]};
                        buf_next        = {2'b00, v6[3:0]};
                        held_next       = 3'd4;
                    end
                    3'd4:
                    begin
                        has_result      = 1'b1;
                        bundle.data_ok  = 1'b1;
                        bundle.bytes[0] = {buf_reg[3:0], v6[5:2]};
                        buf_next        = {4'b0000, v6[1:0]};
                        held_next       = 3'd2;
                    end
                    default:
                    begin
                        has_result      = 1'b1;
                        bundle.data_ok  = 1'b1;
                        bundle.bytes[0] = {buf_reg[1:0], v6};
                        buf_next        = '0;
                        held_next       = 3'd0;
                    end
                endcase
            end
            if (last_item)
            begin
                has_result     = 1'b1;
                bundle.msg_end = 1'b1;
            end
        end
        if (last_item)
        begin
            buf_next  = '0;
            held_next = 3'd0;
            pad_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            buf_reg  <= '0;
            held_reg <= 3'd0;
            pad_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_mode;
            buf_reg  <= '0;
            held_reg <= 3'd0;
            pad_reg  <= 1'b0;
        end
        else if (take)
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
            pad_reg  <= pad_next;
        end
    end

    // encode mode never leaves an odd bit count behind
    a_enc_held_even: assert property (@(posedge clk) disable iff (!rst_n)
        !mode_reg |-> held_reg[0] == 1'b0 && held_reg != 3'd6)
        else $error("encode bit count out of range");

endmodule

[hw/rtl/b64sc_queue.sv]
// small register queue of result bundles between front and back
module b64sc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_full,
    output logic             q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("bundle queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("bundle queue read while empty");

endmodule

[hw/rtl/b64sc_back.sv]
// back end: unpacks bundles into single result beats behind an output register
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  b64sc_bundle_t head,
    input  logic          head_empty,
    output logic          head_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          out_valid,
    output logic          run_last,
    output logic          message_end,
    output logic          bad_char
);

    logic       vld_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg;
    logic       ok_reg, run_last_reg, end_reg, bad_reg;
    logic       load, final_beat;

    assign empty       = !vld_reg;
    assign out_byte    = byte_reg;
    assign out_valid   = ok_reg;
    assign run_last    = run_last_reg;
    assign message_end = end_reg;
    assign bad_char    = bad_reg;

    assign load       = (!vld_reg || pop) && !head_empty;
    assign final_beat = (idx_reg == head.last_idx);
    assign head_pop   = load && final_beat;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head.bytes[idx_reg];
            ok_reg       <= head.data_ok;
            bad_reg      <= head.bad;
            run_last_reg <= final_beat;
            end_reg      <= final_beat && head.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                vld_reg <= 1'b1;
                idx_reg <= final_beat ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && message_end |-> run_last)
        else $error("message end beat is not the last of its item");

    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && bad_char |-> !out_valid && run_last)
        else $error("rejected character beat carries data");

endmodule

[hw/rtl/base64_stream_codec_top.sv]
// top level of the streaming base64 encoder and decoder
//
//  channel  | handshake              | beat
//  ---------+------------------------+------------------------------------------
//  input    | push / full            | data_byte, last_item
//  result   | empty / pop            | out_byte, out_valid, run_last,
//           |                        | message_end, bad_char
//  config   | psel penable pwrite    | paddr, pwdata, prdata (decode_mode at 0)
//
//  an input beat is taken every cycle while the bundle queue has room
//  each input beat yields 0 to 4 result beats (encode averages 4/3, decode
//  at most 1); the output register drains one result beat per cycle while
//  the sink pops, and a queued bundle stays until its last beat is loaded
//  an input beat's results pass through the bundle queue, then the output register
//  rst_n clears mode, bit buffer, queue and output valid flag at once
module base64_stream_codec_top
    import b64sc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_item,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        run_last,
    output logic        message_end,
    output logic        bad_char,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BW = $bits(b64sc_bundle_t);

    logic          take, has_result, mode, cfg_we, q_full, q_empty, q_pop;
    b64sc_bundle_t bnd, head;
    logic [BW-1:0] head_bits;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_DECODE_MODE);
    assign prdata = (paddr[2] == REG_DECODE_MODE) ? {31'd0, mode} : 32'd0;

    assign full = q_full;
    assign take = push && !q_full;
    assign head = b64sc_bundle_t'(head_bits);

    b64sc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last_item  (last_item),
        .take       (take),
        .cfg_we     (cfg_we),
        .cfg_mode   (pwdata[0]),
        .mode       (mode),
        .has_result (has_result),
        .bundle     (bnd)
    );

    b64sc_queue #(
        .WIDTH (BW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take && has_result),
        .wr_data (bnd),
        .rd_en   (q_pop),
        .rd_data (head_bits),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    b64sc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_empty  (q_empty),
        .head_pop    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .out_valid   (out_valid),
        .run_last    (run_last),
        .message_end (message_end),
        .bad_char    (bad_char)
    );

endmodule

[test/tb_base64_stream_codec_top.sv]
// self-checking testbench for the streaming base64 encoder and decoder
`timescale 1ns / 100ps

module tb_base64_stream_codec_top;
    import b64sc_pkg::*;

    localparam logic       MODE_ENCODE   = 1'b0;
    localparam logic       MODE_DECODE   = 1'b1;
    localparam logic [2:0] MODE_ADDR     = 3'(4 * int'(REG_DECODE_MODE));
    localparam int         SETTLE_CYCLES = 8;
    localparam int         LONG_HOLD     = 120;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         PHASE_ITEMS   = 28;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       message_end;
        logic       bad_char;
    } beat_t;

    typedef struct {
        logic        mode;
        logic [7:0]  data;
        logic        last;
        int          n_typed;
        beat_t [3:0] typed;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last_item;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        run_last;
    logic        message_end;
    logic        bad_char;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    string     alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    int        char_val[256];

    logic       decode_q = MODE_ENCODE;
    logic [5:0] pend_bits = '0;
    logic [2:0] pend_cnt = '0;
    logic       pad_seen = 1'b0;
    beat_t      predicted[4];
    beat_t      pending_beats[$];
    stim_row_t  script_rows[$];

    int tx_max_gap = 9;
    int rx_max_stall = 9;
    int drain_hold_req = 0;
    int mismatches = 0;
    int items_in = 0;
    int beats_out = 0;
    int bad_beats = 0;
    int held_cycles = 0;
    int msgs_enc = 0;
    int msgs_dec = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    base64_stream_codec_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .last_item   (last_item),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_valid   (out_valid),
        .run_last    (run_last),
        .message_end (message_end),
        .bad_char    (bad_char),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    function automatic beat_t mk_beat(input logic [7:0] b, input logic v, input logic rl,
                                      input logic me, input logic bad);
        beat_t r;
        r.out_byte    = b;
        r.out_valid   = v;
        r.run_last    = rl;
        r.message_end = me;
        r.bad_char    = bad;
        return r;
    endfunction

    function automatic void add_row(input logic mode, input logic [7:0] d, input logic l,
                                    input int n = -1, input beat_t b0 = '0,
                                    input beat_t b1 = '0, input beat_t b2 = '0,
                                    input beat_t b3 = '0);
        stim_row_t row;
        row.mode    = mode;
        row.data    = d;
        row.last    = l;
        row.n_typed = n;
        row.typed   = {b3, b2, b1, b0};
        script_rows.push_back(row);
    endfunction

    // fills predicted[] with the beats one input byte causes, returns their count
    function automatic int codec_predict(input logic [7:0] d, input logic l);
        logic [15:0] acc;
        int          total;
        int          v;
        int          n;
        n = 0;
        if (decode_q == MODE_ENCODE)
        begin
            acc   = {2'b00, pend_bits, d};
            total = pend_cnt + 8;
            while (total >= 6)
            begin
                total -= 6;
                predicted[n] = mk_beat(alpha[int'(acc >> total) & 63], 1'b1, 1'b0, 1'b0, 1'b0);
                n++;
            end
            acc &= (16'd1 << total) - 16'd1;
            pend_bits = acc[5:0];
            pend_cnt  = 3'(total);
            if (l && total > 0)
            begin
                predicted[n] = mk_beat(alpha[int'(acc << (6 - total)) & 63],
                                       1'b1, 1'b0, 1'b0, 1'b0);
                predicted[n + 1] = mk_beat(PAD_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
                n += 2;
                if (total == 2)
                begin
                    predicted[n] = mk_beat(PAD_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
                    n++;
                end
            end
        end
        else
        begin
            v = char_val[d];
            if (v == int'(VAL_PAD))
            begin
                pad_seen = 1'b1;
            end
            else if (v == int'(VAL_BAD) || pad_seen)
            begin
                predicted[n] = mk_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                n++;
            end
            else
            begin
                acc   = {4'b0000, pend_bits, 6'(v)};
                total = pend_cnt + 6;
                if (total >= 8)
                begin
                    total -= 8;
                    predicted[n] = mk_beat(8'(acc >> total), 1'b1, 1'b0, 1'b0, 1'b0);
                    n++;
                end
                acc &= (16'd1 << total) - 16'd1;
                pend_bits = acc[5:0];
                pend_cnt  = 3'(total);
            end
            if (l && n == 0)
            begin
                predicted[n] = mk_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
                n++;
            end
        end
        if (l)
        begin
            pend_bits = '0;
            pend_cnt  = '0;
            pad_seen  = 1'b0;
        end
        if (n > 0)
        begin
            predicted[n - 1].run_last    = 1'b1;
            predicted[n - 1].message_end = l;
        end
        return n;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_beat(input logic [7:0] d, input logic l, input int n_typed,
                             input beat_t [3:0] typed);
        int gap;
        int n;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= d;
        last_item <= l;
        do @(posedge clk); while (full !== 1'b0);
        n = codec_predict(d, l);
        if (n_typed < 0)
        begin
            for (int k = 0; k < n; k++) pending_beats.push_back(predicted[k]);
        end
        else
        begin
            for (int k = 0; k < n_typed; k++) pending_beats.push_back(typed[k]);
        end
        items_in++;
        if (l && decode_q == MODE_DECODE)
        begin
            msgs_dec++;
        end
        else if (l)
        begin
            msgs_enc++;
        end
    endtask

    // mode changes only once the block has gone quiet
    task automatic set_decode_mode(input logic m);
        logic [31:0] rd;
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'b0, m};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        decode_q  = m;
        pend_bits = '0;
        pend_cnt  = '0;
        pad_seen  = 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("decode_mode", {7'b0, m}, {7'b0, rd[0]});
    endtask

    task automatic send_binary_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
        begin
            send_beat(8'($urandom_range(0, 255)), k == len - 1, -1, '0);
        end
    endtask

    task automatic send_text_message();
        int         len;
        int         pads;
        int         pick;
        logic [7:0] c;
        if ($urandom_range(0, 4) != 0)
        begin
            len  = 4 * $urandom_range(1, 3);
            pads = $urandom_range(0, 2);
            for (int k = 0; k < len; k++)
            begin
                c = (k >= len - pads) ? PAD_CHAR : alpha[$urandom_range(0, 63)];
                send_beat(c, k == len - 1, -1, '0);
            end
        end
        else
        begin
            // broken text: stray padding, data after padding, foreign bytes
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    c = alpha[$urandom_range(0, 63)];
                end
                else if (pick < 7)
                begin
                    c = PAD_CHAR;
                end
                else
                begin
                    c = 8'($urandom_range(0, 255));
                end
                send_beat(c, k == len - 1, -1, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : result_sink
        int    stall;
        beat_t want;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (drain_hold_req != 0)
            begin
                stall          = LONG_HOLD;
                drain_hold_req = 0;
                held_cycles   += LONG_HOLD;
            end
            else
            begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            beats_out++;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat: out_byte %0h", out_byte);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (want.bad_char)
                begin
                    bad_beats++;
                end
                check_field("out_byte", want.out_byte, out_byte);
                check_field("out_valid", {7'b0, want.out_valid}, {7'b0, out_valid});
                check_field("run_last", {7'b0, want.run_last}, {7'b0, run_last});
                check_field("message_end", {7'b0, want.message_end}, {7'b0, message_end});
                check_field("bad_char", {7'b0, want.bad_char}, {7'b0, bad_char});
            end
        end
    end

    initial
    begin : stimulus
        int  phase_start;
        bit  paused;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        data_byte <= 8'h00;
        last_item <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        paused     = 1'b0;

        foreach (char_val[i]) char_val[i] = int'(VAL_BAD);
        for (int i = 0; i < 64; i++) char_val[alpha[i]] = i;
        char_val[PAD_CHAR] = int'(VAL_PAD);

        // encode: all-zero and all-one bytes, short messages of each length mod 3
        add_row(MODE_ENCODE, 8'h00, 1'b1, 4, mk_beat("A", 1'b1, 1'b0, 1'b0, 1'b0),
                mk_beat("A", 1'b1, 1'b0, 1'b0, 1'b0),
                mk_beat(PAD_CHAR, 1'b1, 1'b0, 1'b0, 1'b0),
                mk_beat(PAD_CHAR, 1'b1, 1'b1, 1'b1, 1'b0));
        add_row(MODE_ENCODE, 8'hFF, 1'b0);
        add_row(MODE_ENCODE, 8'hFF, 1'b0);
        add_row(MODE_ENCODE, 8'hFF, 1'b1);
        add_row(MODE_ENCODE, 8'h4D, 1'b0);
        add_row(MODE_ENCODE, 8'h61, 1'b1);
        add_row(MODE_ENCODE, 8'h80, 1'b1);
        // decode: alphabet edges, foreign bytes, padding and data after it
        add_row(MODE_DECODE, "A", 1'b0);
        add_row(MODE_DECODE, "z", 1'b0);
        add_row(MODE_DECODE, "0", 1'b0);
        add_row(MODE_DECODE, "9", 1'b0);
        add_row(MODE_DECODE, "+", 1'b0);
        add_row(MODE_DECODE, "/", 1'b1);
        add_row(MODE_DECODE, 8'h00, 1'b0, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row(MODE_DECODE, 8'hFF, 1'b0, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row(MODE_DECODE, PAD_CHAR, 1'b0);
        add_row(MODE_DECODE, "Q", 1'b0, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        add_row(MODE_DECODE, PAD_CHAR, 1'b1, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        add_row(MODE_DECODE, 8'h7F, 1'b1, 1, mk_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        add_row(MODE_DECODE, "T", 1'b0);
        add_row(MODE_DECODE, "W", 1'b0);
        add_row(MODE_DECODE, "F", 1'b0);
        add_row(MODE_DECODE, "u", 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
        begin
            if (script_rows[i].mode !== decode_q)
            begin
                set_decode_mode(script_rows[i].mode);
            end
            send_beat(script_rows[i].data, script_rows[i].last, script_rows[i].n_typed,
                      script_rows[i].typed);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            set_decode_mode((ph % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
            tx_max_gap   = (ph == 1 || ph == 2) ? 0 : 9;
            rx_max_stall = (ph == 1) ? 0 : 9;
            if (ph == 2)
            begin
                // stall the sink while bytes keep coming so the block backs up
                drain_hold_req = 1;
            end
            phase_start = items_in;
            while (items_in - phase_start < PHASE_ITEMS)
            begin
                if (ph == 4 && !paused && items_in - phase_start >= PHASE_ITEMS / 2)
                begin
                    push <= 1'b0;
                    while (pending_beats.size() != 0) @(posedge clk);
                    @(posedge clk);
                    paused = 1'b1;
                end
                if (decode_q == MODE_DECODE)
                begin
                    send_text_message();
                end
                else
                begin
                    send_binary_message();
                end
            end
        end

        push <= 1'b0;
        rx_max_stall = 0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d input beats and %0d result beats in %0d encoded, %0d decoded messages",
                 items_in, beats_out, msgs_enc, msgs_dec);
        $display("%0d rejected characters, sink held off %0d cycles, both modes written",
                 bad_beats, held_cycles);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/b64sc_pkg.sv
hw/rtl/b64sc_front.sv
hw/rtl/b64sc_queue.sv
hw/rtl/b64sc_back.sv
hw/rtl/base64_stream_codec_top.sv
test/tb_base64_stream_codec_top.sv
